// File: design/gns_pkg.sv
package gns_pkg;

  typedef logic [1:0] dims_t;

  localparam dims_t DIMS_1D = 2'd1;
  localparam dims_t DIMS_2D = 2'd2;
  localparam dims_t DIMS_3D = 2'd3;

  localparam logic [23:0] OFFSET_3D = 24'd19052;
  localparam logic [8:0]  SCALE_3D  = 9'd440;
  localparam logic [23:0] OFFSET_2D = 24'd17308;
  localparam logic [8:0]  SCALE_2D  = 9'd484;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,  8'd201, 8'd95,  8'd96,
    8'd53,  8'd194, 8'd233, 8'd7,   8'd225, 8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142,
    8'd8,   8'd99,  8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148, 8'd247,
    8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,  8'd94,  8'd252, 8'd219, 8'd203,
    8'd117, 8'd35,  8'd11,  8'd32,  8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,
    8'd87,  8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175, 8'd74,  8'd165,
    8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166, 8'd77,  8'd146, 8'd158, 8'd231, 8'd83,
    8'd111, 8'd229, 8'd122, 8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,  8'd65,  8'd25,  8'd63,
    8'd161, 8'd1,   8'd216, 8'd80,  8'd73,  8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,
    8'd18,  8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,  8'd164,
    8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,  8'd52,  8'd217, 8'd226, 8'd250,
    8'd124, 8'd123, 8'd5,   8'd202, 8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,
    8'd212, 8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,  8'd182, 8'd189,
    8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2,   8'd44,
    8'd154, 8'd163, 8'd70,  8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110, 8'd79,  8'd113, 8'd224,
    8'd232, 8'd178, 8'd185, 8'd112, 8'd104, 8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,
    8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241, 8'd81,
    8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107, 8'd49,  8'd192, 8'd214, 8'd31,
    8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,
    8'd45,  8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,  8'd222, 8'd114,
    8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141, 8'd128, 8'd195, 8'd78,  8'd66,  8'd215,
    8'd61,  8'd156, 8'd180
  };

  function automatic logic [7:0] perm(input logic [7:0] i);
    return PERM_ROM[i];
  endfunction

  // quadratic in-out easing of a 16-bit fraction
  function automatic logic [15:0] ease(input logic [15:0] f);
    logic [15:0] j;
    logic [31:0] p;
    logic [15:0] e;
    j = f[15] ? ~f : f;
    p = 32'(j) * (32'(j) + 32'd1);
    e = {p[30:16], 1'b0};
    return f[15] ? ~e : e;
  endfunction

  // corner gradient for the selected dimension count
  function automatic logic [15:0] grad(input dims_t dims, input logic [7:0] h,
                                       input logic [15:0] x, input logic [15:0] y,
                                       input logic [15:0] z);
    logic [15:0] u;
    logic [15:0] v;
    logic [3:0]  h4;
    logic [16:0] s;
    h4 = h[3:0];
    if (dims == DIMS_3D) begin
      u = (h4 < 4'd8) ? x : y;
      if (h4 < 4'd4) v = y;
      else if (h4 == 4'd12 || h4 == 4'd14) v = x;
      else v = z;
    end else if (dims == DIMS_2D) begin
      u = h[2] ? y : x;
      v = h[2] ? x : y;
    end else begin
      if (h4 > 4'd8) begin
        u = x;
        v = x;
      end else if (h4 < 4'd4) begin
        u = x;
        v = 16'd1;
      end else begin
        u = 16'd1;
        v = x;
      end
    end
    if (h[0]) u = 16'd0 - u;
    if (h[1]) v = 16'd0 - v;
    s = {{2{u[15]}}, u[15:1]} + {{2{v[15]}}, v[15:1]} + {16'd0, u[0]};
    return s[15:0];
  endfunction

endpackage

// File: design/gradient_noise_16bit_unit.sv
// Fixed-point gradient noise in 1, 2 or 3 dimensions from 16.16 coordinates. A new
// transaction is taken every cycle unless the output stalls; the pipeline has ten register
// stages (hash, second hash, corner gradients, three blend levels and the output scaling),
// and the whole pipeline holds while the output waits for out_ready. The user must write the
// dimension count on the cfg port only while no transaction is in flight; the block itself
// does not enforce this.
module gradient_noise_16bit_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_dimensions,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_x_coord,
  input  logic [31:0] in_y_coord,
  input  logic [31:0] in_z_coord,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_noise_value
);

  localparam int unsigned Depth = 10;

  gns_pkg::dims_t dims_r;
  logic [Depth-1:0] vld_r;
  logic adv;
  logic is3, is2;

  assign adv       = ~vld_r[Depth-1] | out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign is3 = (dims_r == gns_pkg::DIMS_3D);
  assign is2 = (dims_r == gns_pkg::DIMS_2D);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= gns_pkg::DIMS_3D;
      vld_r  <= '0;
    end else begin
      if (cfg_valid) dims_r <= cfg_dimensions;
      if (adv) vld_r <= {vld_r[Depth-2:0], in_valid};
    end
  end

  // stage 0: first hash and easing
  logic [7:0]  cy_eff, cz_eff;
  logic [7:0]  s0_a_nxt, s0_b_nxt;
  logic [7:0]  s0_a_r, s0_b_r, s0_cz_r;
  logic [14:0] s0_fx_r, s0_fy_r, s0_fz_r;
  logic [15:0] s0_eu_r, s0_ev_r, s0_ew_r;

  assign cy_eff   = (is3 | is2) ? in_y_coord[23:16] : 8'd0;
  assign cz_eff   = is3 ? in_z_coord[23:16] : 8'd0;
  assign s0_a_nxt = gns_pkg::perm(in_x_coord[23:16]) + cy_eff;
  assign s0_b_nxt = gns_pkg::perm(in_x_coord[23:16] + 8'd1) + cy_eff;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_a_r  <= s0_a_nxt;
      s0_b_r  <= s0_b_nxt;
      s0_cz_r <= cz_eff;
      s0_fx_r <= in_x_coord[15:1];
      s0_fy_r <= in_y_coord[15:1];
      s0_fz_r <= in_z_coord[15:1];
      s0_eu_r <= gns_pkg::ease(in_x_coord[15:0]);
      s0_ev_r <= (is3 | is2) ? gns_pkg::ease(in_y_coord[15:0]) : 16'd0;
      s0_ew_r <= is3 ? gns_pkg::ease(in_z_coord[15:0]) : 16'd0;
    end
  end

  // stage 1: second hash
  logic [7:0]  s1_aa_r, s1_ab_r, s1_ba_r, s1_bb_r;
  logic [14:0] s1_fx_r, s1_fy_r, s1_fz_r;
  logic [15:0] s1_eu_r, s1_ev_r, s1_ew_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_aa_r <= gns_pkg::perm(s0_a_r) + s0_cz_r;
      s1_ab_r <= gns_pkg::perm(s0_a_r + 8'd1) + s0_cz_r;
      s1_ba_r <= gns_pkg::perm(s0_b_r) + s0_cz_r;
      s1_bb_r <= gns_pkg::perm(s0_b_r + 8'd1) + s0_cz_r;
      s1_fx_r <= s0_fx_r;
      s1_fy_r <= s0_fy_r;
      s1_fz_r <= s0_fz_r;
      s1_eu_r <= s0_eu_r;
      s1_ev_r <= s0_ev_r;
      s1_ew_r <= s0_ew_r;
    end
  end

  // stage 2: corner hashes and gradients
  logic [15:0] px, py, pz, qx, qy, qz;
  logic [7:0]  hc [8];
  logic [15:0] g_nxt [8];
  logic [15:0] s2_g_r [8];
  logic [15:0] s2_eu_r, s2_ev_r, s2_ew_r;

  assign px = {1'b0, s1_fx_r};
  assign py = {1'b0, s1_fy_r};
  assign pz = {1'b0, s1_fz_r};
  assign qx = {1'b1, s1_fx_r};
  assign qy = {1'b1, s1_fy_r};
  assign qz = {1'b1, s1_fz_r};

  always_comb begin
    hc[0] = gns_pkg::perm(s1_aa_r);
    hc[1] = gns_pkg::perm(s1_ba_r);
    hc[2] = gns_pkg::perm(s1_ab_r);
    hc[3] = gns_pkg::perm(s1_bb_r);
    hc[4] = gns_pkg::perm(s1_aa_r + 8'd1);
    hc[5] = gns_pkg::perm(s1_ba_r + 8'd1);
    hc[6] = gns_pkg::perm(s1_ab_r + 8'd1);
    hc[7] = gns_pkg::perm(s1_bb_r + 8'd1);
    g_nxt[0] = gns_pkg::grad(dims_r, hc[0], px, py, pz);
    g_nxt[1] = gns_pkg::grad(dims_r, hc[1], qx, py, pz);
    g_nxt[2] = gns_pkg::grad(dims_r, hc[2], px, qy, pz);
    g_nxt[3] = gns_pkg::grad(dims_r, hc[3], qx, qy, pz);
    g_nxt[4] = gns_pkg::grad(dims_r, hc[4], px, py, qz);
    g_nxt[5] = gns_pkg::grad(dims_r, hc[5], qx, py, qz);
    g_nxt[6] = gns_pkg::grad(dims_r, hc[6], px, qy, qz);
    g_nxt[7] = gns_pkg::grad(dims_r, hc[7], qx, qy, qz);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_g_r  <= g_nxt;
      s2_eu_r <= s1_eu_r;
      s2_ev_r <= s1_ev_r;
      s2_ew_r <= s1_ew_r;
    end
  end

  // blend levels, unused axes carry a zero weight so the first operand passes
  logic [15:0] ev_d_r [2];
  logic [15:0] ew_d_r [4];
  logic [15:0] r_y [4];
  logic [15:0] s_y [2];
  logic [15:0] raw;

  always_ff @(posedge clk) begin
    if (adv) begin
      ev_d_r <= '{s2_ev_r, ev_d_r[0]};
      ew_d_r <= '{s2_ew_r, ew_d_r[0], ew_d_r[1], ew_d_r[2]};
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_l1
    gns_lerp u_lerp (
      .clk(clk), .en(adv), .a(s2_g_r[2*i]), .b(s2_g_r[2*i+1]), .f(s2_eu_r), .y(r_y[i])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_l2
    gns_lerp u_lerp (
      .clk(clk), .en(adv), .a(r_y[2*i]), .b(r_y[2*i+1]), .f(ev_d_r[1]), .y(s_y[i])
    );
  end

  gns_lerp u_l3 (
    .clk(clk), .en(adv), .a(s_y[0]), .b(s_y[1]), .f(ew_d_r[3]), .y(raw)
  );

  // output scaling
  logic [23:0] sum3, sum2;
  logic [32:0] prod3, prod2;
  logic [15:0] noise_nxt;
  logic [15:0] noise_r;

  always_comb begin
    sum3  = {{8{raw[15]}}, raw} + gns_pkg::OFFSET_3D;
    sum2  = {{8{raw[15]}}, raw} + gns_pkg::OFFSET_2D;
    prod3 = 33'(sum3) * 33'(gns_pkg::SCALE_3D);
    prod2 = 33'(sum2) * 33'(gns_pkg::SCALE_2D);
    if (is3) noise_nxt = prod3[23:8];
    else if (is2) noise_nxt = prod2[23:8];
    else noise_nxt = {sum2[14:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) noise_r <= noise_nxt;
  end

  assign out_valid       = vld_r[Depth-1];
  assign out_noise_value = noise_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted transaction not in first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !vld_r[Depth-2]) |=> !out_valid)
    else $error("result repeated");

endmodule

// File: design/gns_lerp.sv
module gns_lerp (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] a,
  input  logic [15:0] b,
  input  logic [15:0] f,
  output logic [15:0] y
);

  logic [15:0] a_r;
  logic [15:0] d_r;
  logic [15:0] f_r;
  logic        gt_r;
  logic [15:0] y_r;

  logic        gt_nxt;
  logic [16:0] diff_nxt;
  logic [31:0] prod;
  logic [15:0] y_nxt;

  always_comb begin
    gt_nxt   = $signed(b) > $signed(a);
    diff_nxt = gt_nxt ? ({b[15], b} - {a[15], a}) : ({a[15], a} - {b[15], b});
    prod     = 32'(d_r) * (32'(f_r) + 32'd1);
    y_nxt    = gt_r ? (a_r + prod[31:16]) : (a_r - prod[31:16]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a;
      d_r  <= diff_nxt[15:0];
      f_r  <= f;
      gt_r <= gt_nxt;
      y_r  <= y_nxt;
    end
  end

  assign y = y_r;

endmodule
